[rtl/core/srrip_pkg.sv]
// Shared constants, command and status types for the SRRIP replacement core.
`timescale 1ns / 1ps
`default_nettype none

package srrip_pkg;

  // Fixed field widths of the access and result beats.
  localparam int SET_IDX_W = 10;
  localparam int HIT_WAY_W = 3;
  localparam int VICTIM_W  = 3;

  // Widest set number the range check has to cover (SET_COUNT up to 65536).
  localparam int SET_EXT_W = 17;
  // Widest way number the way checks have to cover (WAY_COUNT up to 32).
  localparam int WAY_EXT_W = 6;

  // Default geometry.
  localparam int DEF_SET_COUNT        = 1024;
  localparam int DEF_WAY_COUNT        = 8;
  localparam int DEF_PREDICTION_WIDTH = 2;

  // Access mode codes.
  localparam logic MODE_MISS = 1'b0;
  localparam logic MODE_HIT  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the access fields
    logic read;     // read the set's prediction row
    logic calc;     // find the largest prediction value of the row
    logic update;   // write back the row and register the result
    logic clear;    // write one row of the reset pass
  } srrip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the reset pass is at its last row
  } srrip_stat_t;

endpackage

`default_nettype wire

[rtl/core/srrip_ram.sv]
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module srrip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/srrip_ctrl.sv]
// Controller state machine: reset pass, then read, reduce and update per access.
`timescale 1ns / 1ps
`default_nettype none

module srrip_ctrl
  import srrip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  output logic             out_valid,
  output srrip_cmd_t       cmd,
  input  wire srrip_stat_t stat
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Commands decoded from the state.
  always_comb begin
    cmd.capture = (state_r == ST_IDLE) && start;
    cmd.read    = (state_r == ST_READ);
    cmd.calc    = (state_r == ST_CALC);
    cmd.update  = (state_r == ST_WRITE);
    cmd.clear   = (state_r == ST_CLEAR);
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_WRITE);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // A result strobe lasts one cycle and finds the block ready again.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held for two cycles");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (cmd.read && busy)) else $error("accepted beat not read");

endmodule

`default_nettype wire

[rtl/core/srrip_dp.sv]
// Datapath: prediction row store, reset-pass counter, aging and victim choice.
`timescale 1ns / 1ps
`default_nettype none

module srrip_dp
  import srrip_pkg::*;
#(
  parameter int SET_COUNT        = DEF_SET_COUNT,
  parameter int WAY_COUNT        = DEF_WAY_COUNT,
  parameter int PREDICTION_WIDTH = DEF_PREDICTION_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire srrip_cmd_t           cmd,
  output srrip_stat_t               stat,
  input  wire logic [SET_IDX_W-1:0] in_set_index,
  input  wire logic                 in_mode,
  input  wire logic [HIT_WAY_W-1:0] in_hit_way,
  output logic      [VICTIM_W-1:0]  out_victim_way,
  output logic                      out_victim_found
);

  localparam int AW    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WW    = $clog2(WAY_COUNT);
  localparam int PW    = PREDICTION_WIDTH;
  localparam int ROW_W = WAY_COUNT * PW;

  localparam logic [PW-1:0] PRED_TOP    = '1;
  localparam logic [PW-1:0] PRED_INSERT = PRED_TOP - PW'(1);
  localparam logic [PW-1:0] PRED_RECENT = '0;

  logic [SET_IDX_W-1:0] set_r;
  logic                 mode_r;
  logic [HIT_WAY_W-1:0] hit_way_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [PW-1:0]        top_r;
  logic [VICTIM_W-1:0]  victim_way_r;
  logic                 victim_found_r;

  logic [SET_EXT_W-1:0] set_ext;
  logic                 set_ok;
  logic                 hit_ok;
  logic [AW-1:0]        set_addr;
  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     new_row;
  logic [PW-1:0]        top_nxt;
  logic [PW-1:0]        gap;
  logic [WW-1:0]        victim;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [ROW_W-1:0]     ram_wr_data;

  // Range checks on the captured access.
  assign set_ext  = SET_EXT_W'(set_r);
  assign set_ok   = set_ext < SET_EXT_W'(SET_COUNT);
  assign hit_ok   = WAY_EXT_W'(hit_way_r) < WAY_EXT_W'(WAY_COUNT);
  assign set_addr = set_ext[AW-1:0];

  // Access field capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r     <= in_set_index;
      mode_r    <= in_mode;
      hit_way_r <= in_hit_way;
    end
  end

  // Reset pass row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign stat.clr_last = (clr_cnt_r == AW'(SET_COUNT - 1));

  // Largest prediction value of the row.
  always_comb begin
    top_nxt = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (rd_row[w*PW +: PW] > top_nxt) top_nxt = rd_row[w*PW +: PW];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      top_r <= top_nxt;
    end
  end

  // Aging, victim search and the row to write back. A way reaches the
  // maximum after aging exactly when it held the row's largest value.
  assign gap = PRED_TOP - top_r;

  always_comb begin
    logic             found;
    logic [PW:0]      sum;
    logic [ROW_W-1:0] aged_row;
    logic [ROW_W-1:0] hit_row;
    found    = 1'b0;
    victim   = '0;
    aged_row = '0;
    hit_row  = rd_row;
    for (int w = 0; w < WAY_COUNT; w++) begin
      sum = {1'b0, rd_row[w*PW +: PW]} + {1'b0, gap};
      aged_row[w*PW +: PW] = (sum > {1'b0, PRED_TOP}) ? PRED_TOP : sum[PW-1:0];
      if (!found && (rd_row[w*PW +: PW] == top_r)) begin
        victim = WW'(w);
        found  = 1'b1;
      end
      if (WAY_EXT_W'(w) == WAY_EXT_W'(hit_way_r)) hit_row[w*PW +: PW] = PRED_RECENT;
    end
    aged_row[victim*PW +: PW] = PRED_INSERT;
    new_row = (mode_r == MODE_HIT) ? hit_row : aged_row;
  end

  // Write port: the reset pass or the update of the accessed set.
  assign ram_wr_en   = cmd.clear ||
                       (cmd.update && set_ok && ((mode_r == MODE_MISS) || hit_ok));
  assign ram_wr_addr = cmd.clear ? clr_cnt_r : set_addr;
  assign ram_wr_data = cmd.clear ? {WAY_COUNT{PRED_TOP}} : new_row;

  srrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.read),
    .rd_addr (set_addr),
    .rd_data (rd_row)
  );

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (set_ok && (mode_r == MODE_MISS)) begin
        victim_way_r   <= VICTIM_W'(WAY_EXT_W'(victim));
        victim_found_r <= 1'b1;
      end else begin
        victim_way_r   <= '0;
        victim_found_r <= 1'b0;
      end
    end
  end

  assign out_victim_way   = victim_way_r;
  assign out_victim_found = victim_found_r;

endmodule

`default_nettype wire

[rtl/core/srrip_replacement_policy_core.sv]
// Top level of the SRRIP replacement core: controller plus datapath.
//
//  Channel  Ports                                      Beat taken when
//  access   start, busy, in_set_index/mode/hit_way     start && !busy at clk edge
//  result   out_valid, out_victim_way/victim_found     out_valid, one cycle, no stall
//
// An access reads the set's row from the single row memory, finds its
// largest value, then writes the updated row back; the result strobe
// comes in the cycle after the write, when busy is already low again.
// After reset a clearing pass writes every row to the maximum value, one row
// a cycle, so busy stays high until the pass ends, before the first access.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module srrip_replacement_policy_core
  import srrip_pkg::*;
#(
  parameter int SET_COUNT        = DEF_SET_COUNT,
  parameter int WAY_COUNT        = DEF_WAY_COUNT,
  parameter int PREDICTION_WIDTH = DEF_PREDICTION_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [SET_IDX_W-1:0] in_set_index,
  input  wire logic                 in_mode,
  input  wire logic [HIT_WAY_W-1:0] in_hit_way,
  output logic                      out_valid,
  output logic      [VICTIM_W-1:0]  out_victim_way,
  output logic                      out_victim_found
);

  srrip_cmd_t  cmd;
  srrip_stat_t stat;

  srrip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  srrip_dp #(
    .SET_COUNT        (SET_COUNT),
    .WAY_COUNT        (WAY_COUNT),
    .PREDICTION_WIDTH (PREDICTION_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_set_index     (in_set_index),
    .in_mode          (in_mode),
    .in_hit_way       (in_hit_way),
    .out_victim_way   (out_victim_way),
    .out_victim_found (out_victim_found)
  );

  // A result with no victim reports way zero.
  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_victim_found) |-> (out_victim_way == '0))
    else $error("way reported without a victim");
  // An accepted beat is answered by a result strobe.
  a_answer_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid) else $error("result beat missing");
  // A hit never reports a victim.
  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_HIT)) |-> ##4 !out_victim_found)
    else $error("victim reported on a hit");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the SRRIP replacement core with a victim prediction scoreboard.
`timescale 1ns / 1ps

module testbench;
  import srrip_pkg::*;

  localparam int SET_COUNT        = DEF_SET_COUNT;
  localparam int WAY_COUNT        = DEF_WAY_COUNT;
  localparam int PREDICTION_WIDTH = DEF_PREDICTION_WIDTH;

  localparam int PRED_TOP    = (1 << PREDICTION_WIDTH) - 1;
  localparam int PRED_RECENT = 0;
  localparam int PRED_INSERT = PRED_TOP - 1;

  localparam int RANDOM_ACCESSES = 1550;
  localparam int CALM_TAIL       = 200;
  localparam int STALL_LIMIT     = 8000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_REPORTS     = 10;
  localparam int HOT_SET_COUNT   = 10;

  // One result beat as the block shows it.
  typedef struct packed {
    logic [VICTIM_W-1:0] way;
    logic                valid;
  } victim_beat_t;

  // Scoreboard: tracks every set's prediction values and the victims still due.
  class victim_tracker;
    logic [PREDICTION_WIDTH-1:0] rrpv [SET_COUNT][WAY_COUNT];
    victim_beat_t                due_victims [$];
    int                          mismatches;

    function new();
      for (int s = 0; s < SET_COUNT; s++)
        for (int w = 0; w < WAY_COUNT; w++)
          rrpv[s][w] = PRED_TOP[PREDICTION_WIDTH-1:0];
      mismatches = 0;
    endfunction

    function int pending();
      return due_victims.size();
    endfunction

    // Apply one accepted access beat and queue the victim it should produce.
    function void record_access(logic [SET_IDX_W-1:0] set_idx, logic mode,
                                logic [HIT_WAY_W-1:0] hit_way);
      victim_beat_t beat;
      int           top;
      int           gap;
      int           aged;
      int           victim;
      bit           found;
      beat   = '0;
      top    = 0;
      victim = 0;
      found  = 0;
      if (int'(set_idx) >= SET_COUNT) begin
        due_victims.push_back(beat);
        return;
      end
      if (mode == MODE_HIT) begin
        if (int'(hit_way) < WAY_COUNT)
          rrpv[set_idx][hit_way] = PRED_RECENT[PREDICTION_WIDTH-1:0];
        due_victims.push_back(beat);
        return;
      end
      // Miss: age the whole set until some way reaches the maximum.
      for (int w = 0; w < WAY_COUNT; w++)
        if (int'(rrpv[set_idx][w]) > top)
          top = int'(rrpv[set_idx][w]);
      gap = PRED_TOP - top;
      for (int w = 0; w < WAY_COUNT; w++) begin
        aged = int'(rrpv[set_idx][w]) + gap;
        if (aged > PRED_TOP)
          aged = PRED_TOP;
        rrpv[set_idx][w] = aged[PREDICTION_WIDTH-1:0];
        if (!found && aged == PRED_TOP) begin
          victim = w;
          found  = 1;
        end
      end
      rrpv[set_idx][victim] = PRED_INSERT[PREDICTION_WIDTH-1:0];
      beat.way   = victim[VICTIM_W-1:0];
      beat.valid = 1'b1;
      due_victims.push_back(beat);
    endfunction

    // Compare one result beat with the oldest victim still due.
    function void check_victim(logic [VICTIM_W-1:0] way, logic valid);
      victim_beat_t want;
      if (due_victims.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result beat: way=%0d valid=%0b", $realtime, way, valid);
        return;
      end
      want = due_victims.pop_front();
      if (way !== want.way || valid !== want.valid) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: victim mismatch: expected way=%0d valid=%0b, got way=%0d valid=%0b",
                   $realtime, want.way, want.valid, way, valid);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [SET_IDX_W-1:0] in_set_index;
  logic                 in_mode;
  logic [HIT_WAY_W-1:0] in_hit_way;
  logic                 out_valid;
  logic [VICTIM_W-1:0]  out_victim_way;
  logic                 out_victim_found;

  victim_tracker        tracker;
  int                   quiet_cycles;
  logic [SET_IDX_W-1:0] hot_sets [HOT_SET_COUNT];

  srrip_replacement_policy_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_set_index     (in_set_index),
    .in_mode          (in_mode),
    .in_hit_way       (in_hit_way),
    .out_valid        (out_valid),
    .out_victim_way   (out_victim_way),
    .out_victim_found (out_victim_found)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result monitor: every strobed beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_victim(out_victim_way, out_victim_found);
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("srrip_replacement_policy_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one access beat and hold it until the block takes it.
  task automatic send_access(logic [SET_IDX_W-1:0] set_idx, logic mode,
                             logic [HIT_WAY_W-1:0] hit_way);
    in_set_index <= set_idx;
    in_mode      <= mode;
    in_hit_way   <= hit_way;
    start        <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    tracker.record_access(set_idx, mode, hit_way);
  endtask

  // Drop start for a short random burst.
  task automatic idle_burst();
    int gap;
    gap = $urandom_range(3, 1);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    int                   idle_pct;
    logic [SET_IDX_W-1:0] set_idx;
    logic                 mode;
    tracker      = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_set_index = '0;
    in_mode      = MODE_MISS;
    in_hit_way   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: fill and age the lowest set, promote both end ways,
    // then work the highest set.
    repeat (9) send_access('0, MODE_MISS, '0);
    send_access('0, MODE_HIT, '0);
    send_access('0, MODE_HIT, '1);
    send_access('0, MODE_MISS, '1);
    send_access('0, MODE_MISS, '0);
    send_access('1, MODE_HIT, '1);
    send_access('1, MODE_MISS, 3'd5);
    send_access('1, MODE_MISS, '0);
    send_access('1, MODE_HIT, '0);
    send_access('1, MODE_MISS, '1);
    idle_burst();

    // A few hot sets, the extremes among them, so that ways age and wrap.
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < HOT_SET_COUNT; i++)
      hot_sets[i] = SET_IDX_W'($urandom_range(SET_COUNT - 1, 0));

    // Random part: mostly hot sets, some scattered accesses, idle rate
    // changing every block of fifty beats.
    idle_pct = 0;
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n % 50 == 0)
        idle_pct = ($urandom_range(2, 0) == 0) ? 0 : 30;
      if ($urandom_range(99, 0) < 80)
        set_idx = hot_sets[$urandom_range(HOT_SET_COUNT - 1, 0)];
      else
        set_idx = SET_IDX_W'($urandom);
      mode = ($urandom_range(99, 0) < 40) ? MODE_HIT : MODE_MISS;
      send_access(set_idx, mode, HIT_WAY_W'($urandom));
      if (n == RANDOM_ACCESSES / 2) begin
        // Hold off until every outstanding victim has come back.
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
          @(posedge clk);
      end else if (n < RANDOM_ACCESSES - CALM_TAIL && $urandom_range(99, 0) < idle_pct) begin
        idle_burst();
      end
    end
    start <= 1'b0;

    // Drain the remaining victims, then allow for the block's latency.
    @(posedge clk);
    while (tracker.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("srrip_replacement_policy_core verification clean");
    end else begin
      $display("srrip_replacement_policy_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/srrip_pkg.sv
rtl/core/srrip_ram.sv
rtl/core/srrip_ctrl.sv
rtl/core/srrip_dp.sv
rtl/core/srrip_replacement_policy_core.sv
sim/testbench.sv
